FILE: rtl/core/lexicographic_permutation_generator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the permutation generator
// Shared forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef LEXICOGRAPHIC_PERMUTATION_GENERATOR_ASSERT_SVH
`define LEXICOGRAPHIC_PERMUTATION_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LPG_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lpg: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LPG_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lpg: next-cycle check failed");

`endif

FILE: rtl/core/lpg_pkg.sv
// ----------------------------------------------------------------------------
// Permutation generator package
// Widths, cell operation codes and the control and link records of the cells.
// ----------------------------------------------------------------------------
package lpg_pkg;

   localparam int MAX_LENGTH_DEF = 8;
   localparam int ELEM_W         = 3;
   localparam int LEN_W          = 4;
   localparam int PACKED_W       = 24;
   localparam int RANK_W         = 16;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_IDENTITY,
      CELL_WRITE,
      CELL_SORT
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [ELEM_W-1:0]   wr_value;
      logic                in_suffix;
      logic                parity;
   } cell_ctrl_type;

   typedef struct packed {
      logic [ELEM_W-1:0]   value;
      logic                in_suffix;
   } cell_link_type;

endpackage

FILE: rtl/core/lpg_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying the restart flag of one request.
// ----------------------------------------------------------------------------
interface lpg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

FILE: rtl/core/lpg_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one packed permutation, its rank and last flag.
// ----------------------------------------------------------------------------
interface lpg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lpg_pkg::PACKED_W-1:0]  perm_packed;
   logic [lpg_pkg::RANK_W-1:0]    perm_index;
   logic                          final_res;

   modport source (output valid, output perm_packed, output perm_index,
                   output final_res, input ready);
   modport sink   (input valid, input perm_packed, input perm_index,
                   input final_res, output ready);
endinterface

FILE: rtl/core/lexicographic_permutation_generator.sv
// ----------------------------------------------------------------------------
// Lexicographic permutation generator
// Each request returns the next permutation of 0..n-1 in lexicographic order,
// packed three bits per element, with its rank and a flag on the last
// (descending) one, after which the sequence wraps to the identity; a request
// with restart set returns to the identity first. n is the 4-bit length
// register (0 acts as 1, values above MAX_LENGTH as MAX_LENGTH); change it only
// with a restart. The response leaves in the cycle after the request is
// accepted, then the row of cells steps the stored permutation: a swap of
// pivot and successor, then MAX_LENGTH odd-even exchange passes that sort the
// suffix; when the emitted permutation is the last, the cells load the
// identity instead and do not step. A new request is taken once the cells are
// done and the response register is free or being read.
// ----------------------------------------------------------------------------
module lexicographic_permutation_generator #(
   parameter int MAX_LENGTH = lpg_pkg::MAX_LENGTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   lpg_req_if.sink                     req_ch,
   lpg_rsp_if.source                   rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [lpg_pkg::LEN_W-1:0]   csr_wr_data
);

   `include "lexicographic_permutation_generator_assert.svh"

   localparam int EW    = lpg_pkg::ELEM_W;
   localparam int LW    = lpg_pkg::LEN_W;
   localparam int PW    = lpg_pkg::PACKED_W;
   localparam int RW    = lpg_pkg::RANK_W;
   localparam int IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWAP,
      ST_SORT
   } state_type;

   state_type              state_ff, state_in;
   logic [LW-1:0]          len_ff, len_in;
   logic [RW-1:0]          rank_ff, rank_in;
   logic [IDX_W-1:0]       pivot_ff, pivot_in;
   logic [IDX_W-1:0]       pass_ff, pass_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]          packed_ff, packed_in;
   logic [RW-1:0]          index_ff, index_in;
   logic                   final_ff, final_in;

   lpg_pkg::cell_ctrl_type ctrl [MAX_LENGTH];
   lpg_pkg::cell_link_type link [MAX_LENGTH];

   logic [LW-1:0]          n_eff;
   logic [EW-1:0]          src [MAX_LENGTH];
   logic [MAX_LENGTH-1:0]  asc;
   logic                   found;
   logic [IDX_W-1:0]       pivot_new;
   logic [PW-1:0]          packed_src;
   logic [RW-1:0]          rank_src;
   logic [MAX_LENGTH-1:0]  suffix;
   logic [EW-1:0]          pivot_value;
   logic [IDX_W-1:0]       succ;
   logic [EW-1:0]          succ_value;
   logic                   req_ready;
   logic                   req_accept;

   // ---------------------------------------------------------------- cells
   for (genvar k = 0; k < MAX_LENGTH; k++) begin : g_cell
      lpg_pkg::cell_link_type left_l;
      lpg_pkg::cell_link_type right_l;
      if (k == 0) begin : g_left_edge
         assign left_l = '0;
      end else begin : g_left
         assign left_l = link[k-1];
      end
      if (k == MAX_LENGTH - 1) begin : g_right_edge
         assign right_l = '0;
      end else begin : g_right
         assign right_l = link[k+1];
      end
      lpg_cell #(.INDEX(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl[k]),
         .left_nbr  (left_l),
         .right_nbr (right_l),
         .to_nbr    (link[k])
      );
   end

   // ------------------------------------------------------- length and source
   always_comb begin
      if (len_ff == '0) begin
         n_eff = LW'(1);
      end else if (len_ff > LW'(MAX_LENGTH)) begin
         n_eff = LW'(MAX_LENGTH);
      end else begin
         n_eff = len_ff;
      end
   end

   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_accept = req_ch.valid && req_ready;
   assign rank_src   = req_ch.restart ? '0 : rank_ff;

   // The emitted permutation and its pivot, taken from the identity on restart.
   always_comb begin
      packed_src = '0;
      asc        = '0;
      found      = 1'b0;
      pivot_new  = '0;
      for (int k = 0; k < MAX_LENGTH; k++) begin
         src[k] = req_ch.restart ? EW'(k) : link[k].value;
      end
      for (int k = 0; k < MAX_LENGTH; k++) begin
         if (LW'(k) < n_eff) begin
            packed_src[EW*k +: EW] = src[k];
         end
      end
      for (int k = 0; k + 1 < MAX_LENGTH; k++) begin
         asc[k] = (LW'(k + 1) < n_eff) && (src[k] < src[k+1]);
      end
      for (int k = 0; k < MAX_LENGTH; k++) begin
         if (asc[k]) begin
            pivot_new = IDX_W'(k);
            found     = 1'b1;
         end
      end
   end

   // Successor: the rightmost suffix element above the pivot value.
   always_comb begin
      pivot_value = '0;
      succ        = '0;
      succ_value  = '0;
      for (int k = 0; k < MAX_LENGTH; k++) begin
         suffix[k] = (k > int'(pivot_ff)) && (LW'(k) < n_eff);
         if (IDX_W'(k) == pivot_ff) begin
            pivot_value = link[k].value;
         end
      end
      for (int k = 0; k < MAX_LENGTH; k++) begin
         if (suffix[k] && (link[k].value > pivot_value)) begin
            succ       = IDX_W'(k);
            succ_value = link[k].value;
         end
      end
   end

   // ---------------------------------------------------------- cell control
   always_comb begin
      for (int k = 0; k < MAX_LENGTH; k++) begin
         ctrl[k].op        = lpg_pkg::CELL_HOLD;
         ctrl[k].wr_value  = '0;
         ctrl[k].in_suffix = suffix[k];
         ctrl[k].parity    = pass_ff[0];
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_ch.restart || !found)) begin
                  ctrl[k].op = lpg_pkg::CELL_IDENTITY;
               end
            end
            ST_SWAP: begin
               if (IDX_W'(k) == pivot_ff) begin
                  ctrl[k].op       = lpg_pkg::CELL_WRITE;
                  ctrl[k].wr_value = succ_value;
               end else if (IDX_W'(k) == succ) begin
                  ctrl[k].op       = lpg_pkg::CELL_WRITE;
                  ctrl[k].wr_value = pivot_value;
               end
            end
            ST_SORT: begin
               ctrl[k].op = lpg_pkg::CELL_SORT;
            end
            default: begin
               ctrl[k].op = lpg_pkg::CELL_HOLD;
            end
         endcase
      end
   end

   // ------------------------------------------------------ sequencer
   always_comb begin
      state_in     = state_ff;
      len_in       = csr_wr_en ? csr_wr_data : len_ff;
      rank_in      = rank_ff;
      pivot_in     = pivot_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      packed_in    = packed_ff;
      index_in     = index_ff;
      final_in     = final_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               packed_in    = packed_src;
               index_in     = rank_src;
               final_in     = !found;
               pivot_in     = pivot_new;
               if (found) begin
                  rank_in  = rank_src + RW'(1);
                  state_in = ST_SWAP;
               end else begin
                  rank_in  = '0;
               end
            end
         end
         ST_SWAP: begin
            pass_in  = '0;
            state_in = ST_SORT;
         end
         ST_SORT: begin
            if (pass_ff == IDX_W'(MAX_LENGTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               pass_in = pass_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LW'(8);
         rank_ff      <= '0;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rank_ff      <= rank_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pivot_ff  <= pivot_in;
      packed_ff <= packed_in;
      index_ff  <= index_in;
      final_ff  <= final_in;
   end

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.perm_packed = packed_ff;
   assign rsp_ch.perm_index  = index_ff;
   assign rsp_ch.final_res   = final_ff;

   // ------------------------------------------------------------ assertions
   `LPG_ASSERT_NXT(a_accept_fills_rsp, clock, reset, req_accept, rsp_valid_ff)
   `LPG_ASSERT_IMP(a_busy_blocks_req, clock, reset, state_ff != ST_IDLE, !req_ready)
   `LPG_ASSERT_NXT(a_wrap_clears_rank, clock, reset, req_accept && !found, rank_ff == '0)
   `LPG_ASSERT_IMP(a_sort_after_swap, clock, reset, state_ff == ST_SORT && pass_ff == '0, $past(state_ff) == ST_SWAP)

endmodule

FILE: rtl/core/lpg_cell.sv
// ----------------------------------------------------------------------------
// Permutation cell
// Holds one element; loads, swaps in a value, or takes part in an odd-even
// exchange with a neighbor inside the suffix being sorted.
// ----------------------------------------------------------------------------
module lpg_cell #(
   parameter int INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lpg_pkg::cell_ctrl_type ctrl,
   input  lpg_pkg::cell_link_type left_nbr,
   input  lpg_pkg::cell_link_type right_nbr,
   output lpg_pkg::cell_link_type to_nbr
);

   localparam int EW = lpg_pkg::ELEM_W;
   localparam logic [EW-1:0] IDENT = EW'(INDEX);
   localparam logic IS_ODD = ((INDEX % 2) == 1);

   logic [EW-1:0] value_ff;
   logic [EW-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         lpg_pkg::CELL_HOLD: begin
            value_in = value_ff;
         end
         lpg_pkg::CELL_IDENTITY: begin
            value_in = IDENT;
         end
         lpg_pkg::CELL_WRITE: begin
            value_in = ctrl.wr_value;
         end
         lpg_pkg::CELL_SORT: begin
            // A pass pairs cell k with k+1 where k has the parity of the pass.
            if (ctrl.parity == IS_ODD) begin
               if (ctrl.in_suffix && right_nbr.in_suffix && (value_ff > right_nbr.value)) begin
                  value_in = right_nbr.value;
               end
            end else begin
               if (ctrl.in_suffix && left_nbr.in_suffix && (left_nbr.value > value_ff)) begin
                  value_in = left_nbr.value;
               end
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= IDENT;
      end else begin
         value_ff <= value_in;
      end
   end

   assign to_nbr.value     = value_ff;
   assign to_nbr.in_suffix = ctrl.in_suffix;

endmodule
